// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL that checks itself.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/glzw_pkg.sv =====
// Shared types and constants of the GIF LZW encoder.
// Used by glzw_ctrl, glzw_dp and gif_lzw_encoder; depends on nothing.
package glzw_pkg;

  localparam int DEF_TABLE_SIZE      = 5021;
  localparam int DEF_MAX_CODE_BITS   = 12;
  localparam int DEF_SUB_BLOCK_BYTES = 254;
  localparam int MIN_CODE_LO         = 2;
  localparam int MIN_CODE_HI         = 8;
  localparam int MIN_CODE_RESET      = 8;
  localparam int CFG_W               = 4;

  // Selects the code that a put operation packs.
  localparam logic [1:0] CSEL_PREFIX = 2'd0;
  localparam logic [1:0] CSEL_CLEAR  = 2'd1;
  localparam logic [1:0] CSEL_END    = 2'd2;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] lzw_byte;
    logic       sub_block_end;
    logic       image_end;
    logic       last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       init;
    logic       clr_start;
    logic       clr_step;
    logic       tbl_reset;
    logic       hash;
    logic       rd;
    logic       adv;
    logic       hit;
    logic       miss;
    logic       miss_free;
    logic       put;
    logic [1:0] csel;
    logic       emit;
    logic       emit_done;
    logic       set_pfx_sym;
    logic       widen;
    logic       end_widen;
    logic       flush_ld;
    logic       fin;
    logic       push_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic started;
    logic lastp;
    logic clr_last;
    logic rd_valid;
    logic rd_match;
    logic probe_last;
    logic total_ge8;
    logic pend_valid;
    logic can_push;
    logic grow;
    logic at_max;
    logic fill_nz;
  } sts_t;

endpackage

// ===== hdl/glzw_ctrl.sv =====
// Sequencer of the GIF LZW encoder: steps one request through hashing,
// probing, code packing and table clearing. Depends on glzw_pkg.
module glzw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  glzw_pkg::sts_t sts,
  output glzw_pkg::cmd_t cmd
);
  import glzw_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_INIT  = 5'd1;
  localparam logic [4:0] S_CLR   = 5'd2;
  localparam logic [4:0] S_PCLR  = 5'd3;
  localparam logic [4:0] S_EMIT  = 5'd4;
  localparam logic [4:0] S_SPFX  = 5'd5;
  localparam logic [4:0] S_HASH  = 5'd6;
  localparam logic [4:0] S_RD    = 5'd7;
  localparam logic [4:0] S_CHK   = 5'd8;
  localparam logic [4:0] S_MPUT  = 5'd9;
  localparam logic [4:0] S_MISS2 = 5'd10;
  localparam logic [4:0] S_TRST  = 5'd11;
  localparam logic [4:0] S_LCHK  = 5'd12;
  localparam logic [4:0] S_END1  = 5'd13;
  localparam logic [4:0] S_PEND  = 5'd14;
  localparam logic [4:0] S_END2  = 5'd15;
  localparam logic [4:0] S_FIN   = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0] state_r, state_nxt;
  logic [4:0] ret_r, ret_nxt;
  logic [4:0] clr_ret_r, clr_ret_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    clr_ret_nxt = clr_ret_r;
    cmd         = '0;
    cmd.csel    = CSEL_PREFIX;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.started ? S_HASH : S_INIT;
        end
      end
      S_INIT: begin
        cmd.init      = 1'b1;
        cmd.clr_start = 1'b1;
        clr_ret_nxt   = S_PCLR;
        state_nxt     = S_CLR;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = clr_ret_r;
        end
      end
      S_PCLR: begin
        cmd.put   = 1'b1;
        cmd.csel  = CSEL_CLEAR;
        ret_nxt   = S_SPFX;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.total_ge8) begin
          if (!sts.pend_valid || sts.can_push) begin
            cmd.emit = 1'b1;
          end
        end else begin
          cmd.emit_done = 1'b1;
          state_nxt     = ret_r;
        end
      end
      S_SPFX: begin
        cmd.set_pfx_sym = 1'b1;
        state_nxt       = S_LCHK;
      end
      S_HASH: begin
        cmd.hash  = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!sts.rd_valid) begin
          cmd.miss      = 1'b1;
          cmd.miss_free = 1'b1;
          state_nxt     = S_MPUT;
        end else if (sts.rd_match) begin
          cmd.hit   = 1'b1;
          state_nxt = S_LCHK;
        end else if (sts.probe_last) begin
          cmd.miss  = 1'b1;
          state_nxt = S_MPUT;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_MPUT: begin
        cmd.put   = 1'b1;
        cmd.csel  = CSEL_PREFIX;
        ret_nxt   = S_MISS2;
        state_nxt = S_EMIT;
      end
      S_MISS2: begin
        cmd.set_pfx_sym = 1'b1;
        if (sts.grow && sts.at_max) begin
          cmd.put   = 1'b1;
          cmd.csel  = CSEL_CLEAR;
          ret_nxt   = S_TRST;
          state_nxt = S_EMIT;
        end else begin
          cmd.widen = sts.grow;
          state_nxt = S_LCHK;
        end
      end
      S_TRST: begin
        cmd.tbl_reset = 1'b1;
        cmd.clr_start = 1'b1;
        clr_ret_nxt   = S_LCHK;
        state_nxt     = S_CLR;
      end
      S_LCHK: begin
        if (sts.lastp) begin
          cmd.put   = 1'b1;
          cmd.csel  = CSEL_PREFIX;
          ret_nxt   = S_END1;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_END1: begin
        cmd.end_widen = 1'b1;
        state_nxt     = S_PEND;
      end
      S_PEND: begin
        cmd.put   = 1'b1;
        cmd.csel  = CSEL_END;
        ret_nxt   = S_END2;
        state_nxt = S_EMIT;
      end
      S_END2: begin
        if (sts.fill_nz) begin
          cmd.flush_ld = 1'b1;
          ret_nxt      = S_FIN;
          state_nxt    = S_EMIT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.can_push) begin
          cmd.push_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ret_r     <= S_IDLE;
      clr_ret_r <= S_IDLE;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      clr_ret_r <= clr_ret_nxt;
    end
  end

endmodule

// ===== hdl/glzw_dp.sv =====
// Datapath of the GIF LZW encoder: dictionary memory, probe registers,
// bit packer, byte holding stage and output register. Depends on glzw_pkg.
module glzw_dp #(
  parameter int TABLE_SIZE      = glzw_pkg::DEF_TABLE_SIZE,
  parameter int MAX_CODE_BITS   = glzw_pkg::DEF_MAX_CODE_BITS,
  parameter int SUB_BLOCK_BYTES = glzw_pkg::DEF_SUB_BLOCK_BYTES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  glzw_pkg::cmd_t               cmd,
  output glzw_pkg::sts_t               sts,
  input  glzw_pkg::in_item_t           in_data,
  input  logic                         cfg_we,
  input  logic [glzw_pkg::CFG_W-1:0]   cfg_min_code_size,
  output logic                         out_valid,
  input  logic                         out_stall,
  output glzw_pkg::out_item_t          out_pay
);
  import glzw_pkg::*;

  localparam int CW    = MAX_CODE_BITS;
  localparam int NW    = MAX_CODE_BITS + 1;
  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int MW    = 1 + 2 * CW + 8;
  localparam int AW    = CW + 8;
  localparam logic [IDX_W:0] TS_V   = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
  localparam logic [7:0] SBB_V = 8'(SUB_BLOCK_BYTES);

  // Configuration and image-wide state.
  logic [CFG_W-1:0] cfg_r;
  logic [3:0]       am_r;
  logic             started_r;
  logic [CW-1:0]    prefix_r;
  logic [NW-1:0]    nfc_r;
  logic [3:0]       width_r;
  logic [2:0]       fill_r;
  logic [7:0]       partial_r;
  logic [7:0]       bc_r;
  logic [7:0]       pix_r;
  logic             lastp_r;

  // Probe state and dictionary memory.
  logic [IDX_W-1:0] ind_r, step_r, clr_addr_r, k_r;
  logic [MW-1:0]    mem [TABLE_SIZE];
  logic [MW-1:0]    rd_r;

  // Bit packer and held byte.
  logic [AW-1:0] acc_r;
  logic [4:0]    total_r;
  logic          pend_valid_r, pend_sbe_r;
  logic [7:0]    pend_byte_r;

  logic          out_valid_r;
  out_item_t     out_r;

  // Derived values.
  logic [3:0]       m_clamp;
  logic [8:0]       s9;
  logic [7:0]       sym;
  logic [CW-1:0]    clr_code;
  logic [NW-1:0]    one_sh, clear_new;
  logic [CW-1:0]    cmask, put_code;
  logic [CW-1:0]    hval;
  logic [IDX_W-1:0] hidx, hstep;
  logic [IDX_W:0]   ind_nxt;
  logic [7:0]       bc_inc;
  logic             can_push;
  logic             rd_v;
  logic [CW-1:0]    rd_code, rd_pfx;
  logic [7:0]       rd_sym;

  always_comb begin
    if (cfg_r < CFG_W'(MIN_CODE_LO)) begin
      m_clamp = 4'(MIN_CODE_LO);
    end else if (cfg_r > CFG_W'(MIN_CODE_HI)) begin
      m_clamp = 4'(MIN_CODE_HI);
    end else begin
      m_clamp = 4'(cfg_r);
    end
  end

  assign s9         = 9'd1 << am_r;
  assign sym        = pix_r & (s9[7:0] - 8'd1);
  assign clr_code   = CW'(1) << am_r;
  assign clear_new  = NW'(1) << m_clamp;
  assign one_sh     = NW'(1) << width_r;
  assign cmask      = one_sh[CW-1:0] - CW'(1);

  always_comb begin
    case (cmd.csel)
      CSEL_PREFIX: put_code = prefix_r;
      CSEL_CLEAR:  put_code = clr_code;
      CSEL_END:    put_code = clr_code + CW'(1);
      default:     put_code = prefix_r;
    endcase
  end

  // The hash never exceeds the code range, which is below the table size,
  // so the modulo reduces to a zero extension.
  assign hval    = {sym, {(CW - 8){1'b0}}} ^ prefix_r;
  assign hidx    = IDX_W'(hval);
  assign hstep   = (hidx == '0) ? IDX_W'(1) : IDX_W'(TS_V - {1'b0, hidx});
  assign ind_nxt = ({1'b0, ind_r} >= {1'b0, step_r}) ? ({1'b0, ind_r} - {1'b0, step_r})
                                                    : ({1'b0, ind_r} + TS_V - {1'b0, step_r});

  assign {rd_v, rd_code, rd_pfx, rd_sym} = rd_r;
  assign bc_inc   = bc_r + 8'd1;
  assign can_push = !out_valid_r || !out_stall;

  always_comb begin
    sts            = '0;
    sts.started    = started_r;
    sts.lastp      = lastp_r;
    sts.clr_last   = (clr_addr_r == LAST_IDX);
    sts.rd_valid   = rd_v;
    sts.rd_match   = rd_v && (rd_pfx == prefix_r) && (rd_sym == sym);
    sts.probe_last = (k_r == LAST_IDX);
    sts.total_ge8  = (total_r >= 5'd8);
    sts.pend_valid = pend_valid_r;
    sts.can_push   = can_push;
    sts.grow       = (nfc_r > one_sh);
    sts.at_max     = (width_r >= 4'(MAX_CODE_BITS));
    sts.fill_nz    = (fill_r != 3'd0);
  end

  // Dictionary memory: one port, registered read.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_addr_r] <= '0;
    end else if (cmd.miss && cmd.miss_free && (nfc_r < (NW'(1) << CW))) begin
      mem[ind_r] <= {1'b1, nfc_r[CW-1:0], prefix_r, sym};
    end
    if (cmd.rd) begin
      rd_r <= mem[ind_r];
    end
  end

  // Probe registers and input capture.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r   <= in_data.pixel;
      lastp_r <= in_data.last_pixel;
    end
    if (cmd.clr_start) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + IDX_W'(1);
    end
    if (cmd.hash) begin
      ind_r  <= hidx;
      step_r <= hstep;
      k_r    <= '0;
    end else if (cmd.adv) begin
      ind_r <= ind_nxt[IDX_W-1:0];
      k_r   <= k_r + IDX_W'(1);
    end
  end

  // Image state, code packing and byte output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r        <= CFG_W'(MIN_CODE_RESET);
      am_r         <= '0;
      started_r    <= 1'b0;
      prefix_r     <= '0;
      nfc_r        <= '0;
      width_r      <= '0;
      fill_r       <= '0;
      partial_r    <= '0;
      bc_r         <= '0;
      acc_r        <= '0;
      total_r      <= '0;
      pend_valid_r <= 1'b0;
      pend_sbe_r   <= 1'b0;
      pend_byte_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_min_code_size;
      end
      if (cmd.init) begin
        am_r      <= m_clamp;
        nfc_r     <= clear_new + NW'(2);
        width_r   <= m_clamp + 4'd1;
        fill_r    <= '0;
        partial_r <= '0;
        bc_r      <= '0;
      end
      if (cmd.tbl_reset) begin
        nfc_r   <= {1'b0, clr_code} + NW'(2);
        width_r <= am_r + 4'd1;
      end
      if (cmd.miss) begin
        nfc_r <= nfc_r + NW'(1);
      end
      if (cmd.hit) begin
        prefix_r <= rd_code;
      end
      if (cmd.set_pfx_sym) begin
        prefix_r  <= CW'(sym);
        started_r <= 1'b1;
      end
      if (cmd.widen) begin
        width_r <= width_r + 4'd1;
      end
      if (cmd.end_widen && (nfc_r >= one_sh) && (width_r < 4'(MAX_CODE_BITS))) begin
        width_r <= width_r + 4'd1;
      end
      if (cmd.put) begin
        acc_r   <= AW'(partial_r) | (AW'(put_code & cmask) << fill_r);
        total_r <= 5'(fill_r) + 5'(width_r);
      end
      if (cmd.flush_ld) begin
        acc_r   <= AW'(partial_r);
        total_r <= 5'd8;
      end
      // One byte leaves the packer; the previously held byte, if any, moves out.
      if (cmd.emit) begin
        pend_valid_r <= 1'b1;
        pend_byte_r  <= acc_r[7:0];
        if (bc_inc >= SBB_V) begin
          pend_sbe_r <= 1'b1;
          bc_r       <= '0;
        end else begin
          pend_sbe_r <= 1'b0;
          bc_r       <= bc_inc;
        end
        acc_r   <= acc_r >> 8;
        total_r <= total_r - 5'd8;
      end
      if (cmd.emit_done) begin
        partial_r <= acc_r[7:0];
        fill_r    <= total_r[2:0];
      end
      if (cmd.fin) begin
        bc_r      <= '0;
        fill_r    <= '0;
        partial_r <= '0;
        started_r <= 1'b0;
      end
      if (cmd.push_last) begin
        pend_valid_r <= 1'b0;
      end
      // Output register.
      if ((cmd.emit && pend_valid_r) || cmd.push_last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && pend_valid_r) begin
      out_r <= '{lzw_byte: pend_byte_r, sub_block_end: pend_sbe_r,
                 image_end: 1'b0, last: 1'b0};
    end else if (cmd.push_last) begin
      out_r <= '{lzw_byte: pend_byte_r, sub_block_end: pend_sbe_r | lastp_r,
                 image_end: lastp_r, last: 1'b1};
    end
  end

  assign out_valid = out_valid_r;
  assign out_pay   = out_r;

endmodule

// ===== hdl/gif_lzw_encoder.sv =====
// The time from one pixel accept to the next grows with each further probe, with a new string,
// with each packed byte and with any output stall. The first pixel of an image also clears the
// dictionary; a table-full clear walks the whole table again; the last pixel also packs the end
// code, and a partial byte if one remains.
// When a request leaves a byte, its final byte is valid at the output in the cycle in which in_stall falls.
// Reset (rst_n, synchronous, active low) idles the block; min_code_size resets to 8.
module gif_lzw_encoder #(
  parameter int TABLE_SIZE      = glzw_pkg::DEF_TABLE_SIZE,
  parameter int MAX_CODE_BITS   = glzw_pkg::DEF_MAX_CODE_BITS,
  parameter int SUB_BLOCK_BYTES = glzw_pkg::DEF_SUB_BLOCK_BYTES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  glzw_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output glzw_pkg::out_item_t        out_pay,
  input  logic                       cfg_we,
  input  logic [glzw_pkg::CFG_W-1:0] cfg_min_code_size
);
  import glzw_pkg::*;
  `include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;

  glzw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  glzw_dp #(
    .TABLE_SIZE      (TABLE_SIZE),
    .MAX_CODE_BITS   (MAX_CODE_BITS),
    .SUB_BLOCK_BYTES (SUB_BLOCK_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_data           (in_data),
    .cfg_we            (cfg_we),
    .cfg_min_code_size (cfg_min_code_size),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pay           (out_pay)
  );

  // A new request never finds a byte held from the previous one.
  `CHK_SAME(a_accept_clean, in_valid && !in_stall, !sts.pend_valid, "byte held at accept")
  // The packer only releases a byte when at least eight bits are present.
  `CHK_SAME(a_emit_full, cmd.emit, sts.total_ge8, "emit with fewer than 8 bits")
  // The closing byte of a request, when the request has one, lands in the output register.
  `CHK_NEXT(a_last_out, cmd.push_last, out_valid && out_pay.last, "last byte lost")

endmodule
